// ===== hdl/lbs_pkg.sv =====
// Shared types and constants for the linear blend skinning core.
package lbs_pkg;

    localparam int ELEMS      = 12;
    localparam int TARGET_W   = 11;
    localparam int ELEMENT_W  = 4;
    localparam int COORD_W    = 32;
    localparam int INF_W      = 16;
    localparam int BONE_W     = 8;
    localparam int WEIGHT_W   = 8;
    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 96;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_BLEND = 2'd1;
    localparam logic [1:0] MODE_POS   = 2'd2;
    localparam logic [1:0] MODE_DIR   = 2'd3;

    // One classified word as it waits between the front and the back end.
    typedef struct packed {
        logic [1:0]                          mode;
        logic                                target_ok;
        logic [TARGET_W-1:0]                 target;
        logic [ELEMENT_W-1:0]                element;
        logic signed [COORD_W-1:0]           x;
        logic signed [COORD_W-1:0]           y;
        logic signed [COORD_W-1:0]           z;
        logic [3:0][BONE_W-1:0]              bone;
        logic [3:0][WEIGHT_W-1:0]            weight;
        logic [3:0]                          bone_ok;
        logic [1:0]                          last_inf;
    } lbs_item_t;

endpackage

// ===== hdl/lbs_front.sv =====
// Front end: accepts input words, classifies them and queues them for the back end.
module lbs_front #(
    parameter int BONE_COUNT = 256,
    parameter int TOTAL_MATS = 1280
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lbs_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                     s_tuser,
    output logic                           q_valid,
    input  logic                           q_pop,
    output lbs_pkg::lbs_item_t             q_item
);

    lbs_pkg::lbs_item_t item_in;
    lbs_pkg::lbs_item_t fifo_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push;
    logic [3:0][lbs_pkg::INF_W-1:0] inf;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            inf[k] = s_tdata[111 + k*16 +: 16];
        end
        item_in.mode      = s_tuser;
        item_in.target    = s_tdata[10:0];
        item_in.target_ok = ({6'd0, s_tdata[10:0]} < 17'(TOTAL_MATS));
        item_in.element   = s_tdata[14:11];
        item_in.x         = $signed(s_tdata[46:15]);
        item_in.y         = $signed(s_tdata[78:47]);
        item_in.z         = $signed(s_tdata[110:79]);
        for (int k = 0; k < 4; k++)
        begin
            item_in.bone[k]    = inf[k][15:8];
            item_in.weight[k]  = inf[k][7:0];
            item_in.bone_ok[k] = ({1'b0, inf[k][15:8]} < 9'(BONE_COUNT));
        end
        // The list ends before the first later influence with zero weight.
        if (inf[1][7:0] == 8'd0)
            item_in.last_inf = 2'd0;
        else if (inf[2][7:0] == 8'd0)
            item_in.last_inf = 2'd1;
        else if (inf[3][7:0] == 8'd0)
            item_in.last_inf = 2'd2;
        else
            item_in.last_inf = 2'd3;
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 2'd1;
        else if (!push && q_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= item_in;
    end

endmodule

// ===== hdl/lbs_back.sv =====
// Back end: matrix store, blend and transform datapaths and the output register.
module lbs_back #(
    parameter int TOTAL_MATS = 1280,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  lbs_pkg::lbs_item_t            q_item,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lbs_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int DEPTH  = (TOTAL_MATS > 2048) ? 2048 : TOTAL_MATS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BRD  = 3'd1;
    localparam logic [2:0] S_BDIV = 3'd2;
    localparam logic [2:0] S_BWR  = 3'd3;
    localparam logic [2:0] S_TRD  = 3'd4;
    localparam logic [2:0] S_TSUM = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    logic       load_out;

    logic [31:0] store_mem [lbs_pkg::ELEMS][DEPTH];
    logic [31:0] rd_data_reg [lbs_pkg::ELEMS];
    logic        rd_en;
    logic [lbs_pkg::TARGET_W-1:0] rd_addr_full;
    logic [lbs_pkg::ELEMS-1:0]    wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [31:0]                  wr_data [lbs_pkg::ELEMS];

    logic signed [42:0] acc_reg [lbs_pkg::ELEMS];
    logic signed [42:0] acc_next [lbs_pkg::ELEMS];
    logic [42:0]        tsum_reg [lbs_pkg::ELEMS];
    logic [42:0]        tsum_next [lbs_pkg::ELEMS];
    logic [10:0]        dsum_reg [lbs_pkg::ELEMS];
    logic [10:0]        dsum_next [lbs_pkg::ELEMS];
    logic [lbs_pkg::ELEMS-1:0] neg_reg, neg_next;
    logic [31:0]        blend_val [lbs_pkg::ELEMS];
    logic signed [63:0] prod_reg [3][3];
    logic signed [31:0] trans_reg [3];
    logic [31:0]        row_out [3];
    logic [31:0]        out_reg [3];

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < lbs_pkg::ELEMS; e++)
        begin
            if (wr_en[e])
                store_mem[e][wr_addr] <= wr_data[e];
            if (rd_en)
                rd_data_reg[e] <= store_mem[e][rd_addr_full[ADDR_W-1:0]];
        end
    end

    // Blend accumulation and final scaling. A magnitude x equals 255 * T + D, where T is
    // the sum of x shifted right by whole bytes and D the sum of its bytes, so the
    // quotient is T plus the small quotient of D.
    always_comb
    begin
        logic [7:0]          w;
        logic signed [31:0]  m;
        logic signed [40:0]  prod;
        logic [42:0]         mag;
        logic [11:0]         dfix;
        logic [43:0]         q;
        for (int e = 0; e < lbs_pkg::ELEMS; e++)
        begin
            w = q_item.weight[k_reg];
            m = q_item.bone_ok[k_reg] ? $signed(rd_data_reg[e]) : 32'sd0;
            prod = $signed({1'b0, w}) * m;
            if (state_reg == S_IDLE)
                acc_next[e] = 43'sd0;
            else if (state_reg == S_BRD)
                acc_next[e] = acc_reg[e] + 43'(prod);
            else
                acc_next[e] = acc_reg[e];

            neg_next[e]  = acc_reg[e][42];
            mag          = acc_reg[e][42] ? 43'(-acc_reg[e]) : 43'(acc_reg[e]);
            tsum_next[e] = {8'd0, mag[42:8]} + {16'd0, mag[42:16]} + {24'd0, mag[42:24]}
                         + {32'd0, mag[42:32]} + {40'd0, mag[42:40]};
            dsum_next[e] = {3'd0, mag[7:0]} + {3'd0, mag[15:8]} + {3'd0, mag[23:16]}
                         + {3'd0, mag[31:24]} + {3'd0, mag[39:32]} + {8'd0, mag[42:40]};

            dfix = {1'b0, dsum_reg[e]} + {9'd0, dsum_reg[e][10:8]} + 12'd1;
            q    = {1'b0, tsum_reg[e]} + {40'd0, dfix[11:8]};
            if (!neg_reg[e])
                blend_val[e] = (q > 44'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            else
                blend_val[e] = (q > 44'h8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
        end
    end

    // Row sums of the transform, floored to the fixed-point grid, plus the translation for positions, saturated.
    always_comb
    begin
        logic signed [65:0] p;
        logic signed [65:0] sh;
        logic signed [66:0] t;
        for (int r = 0; r < 3; r++)
        begin
            p  = 66'(prod_reg[r][0]) + 66'(prod_reg[r][1]) + 66'(prod_reg[r][2]);
            sh = p >>> FRAC_BITS;
            t  = 67'(sh);
            if (q_item.mode == lbs_pkg::MODE_POS)
                t = t + 67'(trans_reg[r]);
            if (t > 67'sh7FFF_FFFF)
                row_out[r] = 32'h7FFF_FFFF;
            else if (t < -67'sh8000_0000)
                row_out[r] = 32'h8000_0000;
            else
                row_out[r] = t[31:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr_full = q_item.target;
        wr_en        = '0;
        wr_addr      = q_item.target[ADDR_W-1:0];
        load_out     = 1'b0;
        for (int e = 0; e < lbs_pkg::ELEMS; e++)
        begin
            wr_data[e] = blend_val[e];
        end
        case (state_reg)
            S_IDLE:
            begin
                k_next = 2'd0;
                if (q_valid)
                begin
                    case (q_item.mode)
                        lbs_pkg::MODE_LOAD:
                        begin
                            for (int e = 0; e < lbs_pkg::ELEMS; e++)
                            begin
                                wr_data[e] = q_item.x;
                                wr_en[e]   = q_item.target_ok && (q_item.element == 4'(e));
                            end
                            q_pop = 1'b1;
                        end
                        lbs_pkg::MODE_BLEND:
                        begin
                            rd_en        = 1'b1;
                            rd_addr_full = {3'd0, q_item.bone[0]};
                            state_next   = S_BRD;
                        end
                        default:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_TRD;
                        end
                    endcase
                end
            end
            S_BRD:
            begin
                if (k_reg == q_item.last_inf)
                    state_next = S_BDIV;
                else
                begin
                    k_next       = k_reg + 2'd1;
                    rd_en        = 1'b1;
                    rd_addr_full = {3'd0, q_item.bone[k_reg + 2'd1]};
                end
            end
            S_BDIV:
            begin
                state_next = S_BWR;
            end
            S_BWR:
            begin
                wr_en      = {lbs_pkg::ELEMS{q_item.target_ok}};
                q_pop      = 1'b1;
                state_next = S_IDLE;
            end
            S_TRD:
            begin
                state_next = S_TSUM;
            end
            S_TSUM:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    q_pop      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int e = 0; e < lbs_pkg::ELEMS; e++)
        begin
            acc_reg[e] <= acc_next[e];
            if (state_reg == S_BDIV)
            begin
                tsum_reg[e] <= tsum_next[e];
                dsum_reg[e] <= dsum_next[e];
                neg_reg[e]  <= neg_next[e];
            end
        end
        if (state_reg == S_TRD)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[r][0] <= $signed(rd_data_reg[r*4])     * q_item.x;
                prod_reg[r][1] <= $signed(rd_data_reg[r*4 + 1]) * q_item.y;
                prod_reg[r][2] <= $signed(rd_data_reg[r*4 + 2]) * q_item.z;
                trans_reg[r]   <= $signed(rd_data_reg[r*4 + 3]);
            end
        end
        if (load_out)
        begin
            for (int r = 0; r < 3; r++)
            begin
                // A transform of a matrix outside the store answers with zeros.
                out_reg[r] <= q_item.target_ok ? row_out[r] : 32'd0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg[2], out_reg[1], out_reg[0]};

`ifndef SYNTH
    a_busy_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> q_valid)
        else $error("back end busy without a queued word");
    a_pop_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");
    a_k_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BRD) |-> (k_reg <= q_item.last_inf))
        else $error("influence counter ran past the list");
`endif

endmodule

// ===== hdl/linear_blend_skinning_core.sv =====
// Linear blend skinning core with four influences: top level.
// Words enter through a two-word queue, so the next word is taken while the back end works
// or a result waits at the output. A load writes a single element; a blend reads its n
// used influences one by one through the single read port of the 384-bit-wide matrix store (one bone
// matrix per cycle), then scales by 1/255 and writes back; a transform runs matrix read, product
// stage and row sum, plus any wait for the output to be taken. The store is not cleared after
// reset: every matrix must be written before it is read.
module linear_blend_skinning_core #(
    parameter int BONE_COUNT  = 256,
    parameter int BLEND_COUNT = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // target, element, coord_x, coord_y, coord_z, influence_0..influence_3, zero fill
    input  logic [175:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z
    output logic [95:0]  m_tdata
);

    localparam int TOTAL_MATS = BONE_COUNT + BLEND_COUNT;

    logic               q_valid;
    logic               q_pop;
    lbs_pkg::lbs_item_t q_item;

    lbs_front #(
        .BONE_COUNT (BONE_COUNT),
        .TOTAL_MATS (TOTAL_MATS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    lbs_back #(
        .TOTAL_MATS (TOTAL_MATS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== bench/tb_linear_blend_skinning_core.sv =====
// Self-checking testbench for the linear blend skinning core.
`timescale 1ns / 100ps

module tb_linear_blend_skinning_core;

    localparam int TOTAL_MATS  = 1280;
    localparam int FRAC        = 16;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 1000;

    typedef struct {
        logic [1:0]                         mode;
        logic [lbs_pkg::TARGET_W-1:0]       target;
        logic [lbs_pkg::ELEMENT_W-1:0]      element;
        logic signed [lbs_pkg::COORD_W-1:0] x;
        logic signed [lbs_pkg::COORD_W-1:0] y;
        logic signed [lbs_pkg::COORD_W-1:0] z;
        logic [lbs_pkg::INF_W-1:0]          inf [4];
    } skin_word_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;

    // Shadow of the matrix store with a per-matrix mask of written elements.
    int         mat_store [TOTAL_MATS*12];
    bit [11:0]  written [TOTAL_MATS];
    int         full_mats[$];
    int         full_bones[$];
    vec_t       pending_vecs[$];

    int  errors;
    int  n_loads;
    int  n_blends;
    int  n_xforms;
    int  n_checked;
    int  idle_count;
    bit  hold_req;

    linear_blend_skinning_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic signed [31:0] sat_wide(logic signed [67:0] v);
        if (v > 68'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -68'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] row_result(int base, logic signed [31:0] x,
                                                     logic signed [31:0] y,
                                                     logic signed [31:0] z, bit pos);
        logic signed [67:0] p;
        logic signed [31:0] m0, m1, m2, m3;
        m0 = mat_store[base];
        m1 = mat_store[base+1];
        m2 = mat_store[base+2];
        m3 = mat_store[base+3];
        p = x * m0 + y * m1 + z * m2;
        // The arithmetic shift floors toward minus infinity.
        p = p >>> FRAC;
        if (pos)
            p = p + m3;
        return sat_wide(p);
    endfunction

    task automatic mark_written(int idx, bit [11:0] mask);
        bit was_full;
        was_full = (written[idx] == 12'hFFF);
        written[idx] |= mask;
        if (!was_full && written[idx] == 12'hFFF)
        begin
            full_mats.push_back(idx);
            if (idx < 256)
                full_bones.push_back(idx);
        end
    endtask

    task automatic predict_word(skin_word_t w);
        longint acc [12];
        longint q;
        int     bone;
        int     wt;
        bit     ok;
        vec_t   v;
        ok = (w.target < TOTAL_MATS);
        case (w.mode)
            lbs_pkg::MODE_LOAD:
            begin
                n_loads++;
                if (ok && w.element < 12)
                begin
                    mat_store[w.target*12 + w.element] = w.x;
                    mark_written(w.target, 12'b1 << w.element);
                end
            end
            lbs_pkg::MODE_BLEND:
            begin
                n_blends++;
                for (int e = 0; e < 12; e++)
                    acc[e] = 0;
                for (int k = 0; k < 4; k++)
                begin
                    bone = w.inf[k][15:8];
                    wt   = w.inf[k][7:0];
                    if (k > 0 && wt == 0)
                        break;
                    for (int e = 0; e < 12; e++)
                        acc[e] += longint'(wt) * longint'(mat_store[bone*12 + e]);
                end
                if (ok)
                begin
                    for (int e = 0; e < 12; e++)
                    begin
                        q = acc[e] / 255;
                        mat_store[w.target*12 + e] = sat_wide(68'(q));
                    end
                    mark_written(w.target, 12'hFFF);
                end
            end
            default:
            begin
                n_xforms++;
                if (ok)
                begin
                    v.x = row_result(w.target*12,     w.x, w.y, w.z,
                                     w.mode == lbs_pkg::MODE_POS);
                    v.y = row_result(w.target*12 + 4, w.x, w.y, w.z,
                                     w.mode == lbs_pkg::MODE_POS);
                    v.z = row_result(w.target*12 + 8, w.x, w.y, w.z,
                                     w.mode == lbs_pkg::MODE_POS);
                end
                else
                begin
                    v.x = 0;
                    v.y = 0;
                    v.z = 0;
                end
                pending_vecs.push_back(v);
            end
        endcase
    endtask

    // Drives one word and returns once it has been taken. The valid is kept high
    // between words sent back to back.
    task automatic send_word(skin_word_t w, int max_gap = 15);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.mode;
        s_tdata  <= {1'b0, w.inf[3], w.inf[2], w.inf[1], w.inf[0], w.z, w.y, w.x,
                     w.element, w.target};
        do
            @(posedge clk);
        while (!s_tready);
        predict_word(w);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'h00010000;
            4: return 32'hFFFF0000;
            5, 6: return $urandom_range(0, 32'h0003FFFF) - 32'h00020000;
            default: return $urandom;
        endcase
    endfunction

    function automatic skin_word_t blank_word(logic [1:0] mode, int target);
        skin_word_t w;
        w.mode    = mode;
        w.target  = lbs_pkg::TARGET_W'(target);
        w.element = lbs_pkg::ELEMENT_W'($urandom_range(0, 15));
        w.x       = rand_value();
        w.y       = rand_value();
        w.z       = rand_value();
        for (int k = 0; k < 4; k++)
            w.inf[k] = lbs_pkg::INF_W'($urandom);
        return w;
    endfunction

    task automatic load_matrix(int idx, bit extremes);
        skin_word_t w;
        int order [12];
        int j, t;
        for (int e = 0; e < 12; e++)
            order[e] = e;
        for (int e = 11; e > 0; e--)
        begin
            j = $urandom_range(0, e);
            t = order[e];
            order[e] = order[j];
            order[j] = t;
        end
        for (int e = 0; e < 12; e++)
        begin
            w = blank_word(lbs_pkg::MODE_LOAD, idx);
            w.element = lbs_pkg::ELEMENT_W'(order[e]);
            if (extremes)
                w.x = order[e][0] ? 32'sh80000000 : 32'sh7FFFFFFF;
            send_word(w);
        end
    endtask

    // A blend over n used influences taken from fully written bones.
    task automatic send_blend(int target, int n, int max_gap = 15);
        skin_word_t w;
        w = blank_word(lbs_pkg::MODE_BLEND, target);
        for (int k = 0; k < 4; k++)
        begin
            if (k < n)
            begin
                w.inf[k][15:8] = 8'(full_bones[$urandom_range(0, full_bones.size()-1)]);
                w.inf[k][7:0]  = (k == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(1, 255));
            end
            else if (k == n)
                w.inf[k][7:0] = 8'd0;
        end
        send_word(w, max_gap);
    endtask

    task automatic send_xform(int target, int max_gap = 15);
        skin_word_t w;
        w = blank_word($urandom_range(0, 1) ? lbs_pkg::MODE_POS : lbs_pkg::MODE_DIR, target);
        send_word(w, max_gap);
    endtask

    task automatic test_directed();
        skin_word_t w;
        load_matrix(0, 1'b1);
        w = blank_word(lbs_pkg::MODE_POS, 0);
        w.x = 32'sh7FFFFFFF;
        w.y = 32'sh80000000;
        w.z = 32'sh7FFFFFFF;
        send_word(w);
        w.mode = lbs_pkg::MODE_DIR;
        send_word(w);
        w.x = 32'sh80000000;
        w.y = 32'sh80000000;
        w.z = 32'sh80000000;
        send_word(w);
        // Transform of a target beyond the store answers with zeros.
        send_word(blank_word(lbs_pkg::MODE_POS, 2047));
        send_word(blank_word(lbs_pkg::MODE_DIR, 1280));
        // Loads to an element or a target out of range are dropped.
        w = blank_word(lbs_pkg::MODE_LOAD, 0);
        w.element = 4'd15;
        send_word(w);
        w = blank_word(lbs_pkg::MODE_LOAD, 1280);
        w.element = 4'd3;
        send_word(w);
        // Influence 0 with zero weight still counts; a zero weight on a later influence ends the list.
        w = blank_word(lbs_pkg::MODE_BLEND, 2);
        w.inf[0] = 16'h0000;
        w.inf[1] = 16'hFF00;
        send_word(w);
        send_xform(2);
        // Four full weights on the extreme matrix saturate every element.
        w = blank_word(lbs_pkg::MODE_BLEND, 1);
        for (int k = 0; k < 4; k++)
            w.inf[k] = 16'h00FF;
        send_word(w);
        send_xform(1);
        // A blend into a target out of range is dropped.
        w.target = 11'd2000;
        send_word(w);
        // A blend whose target is one of its bones reads the old values.
        w = blank_word(lbs_pkg::MODE_BLEND, 0);
        w.inf[0] = 16'h0080;
        w.inf[1] = 16'h0040;
        w.inf[2] = 16'h0000;
        send_word(w);
        send_xform(0);
    endtask

    task automatic test_random();
        skin_word_t w;
        int r, sent;
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 12 || full_mats.size() < 4)
            begin
                load_matrix($urandom_range(0, 3) != 0 ? $urandom_range(0, 255)
                                                      : $urandom_range(256, TOTAL_MATS-1),
                            1'b0);
                sent += 12;
            end
            else if (r < 40)
            begin
                send_blend($urandom_range(0, 15) != 0 ? $urandom_range(0, TOTAL_MATS-1)
                                                      : $urandom_range(TOTAL_MATS, 2047),
                           $urandom_range(1, 4));
                sent++;
            end
            else if (r < 88)
            begin
                send_xform($urandom_range(0, 19) != 0
                           ? full_mats[$urandom_range(0, full_mats.size()-1)]
                           : $urandom_range(TOTAL_MATS, 2047));
                sent++;
            end
            else
            begin
                // Stray loads: bad elements, bad targets, or a single element rewrite.
                w = blank_word(lbs_pkg::MODE_LOAD, $urandom_range(0, 2047));
                if (w.target < TOTAL_MATS && w.element < 12 && written[w.target] != 12'hFFF)
                    w.target = lbs_pkg::TARGET_W'(
                        full_mats[$urandom_range(0, full_mats.size()-1)]);
                send_word(w);
                sent++;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 5 == 4)
                send_blend($urandom_range(256, TOTAL_MATS-1), $urandom_range(1, 4), 0);
            else
                send_xform(full_mats[$urandom_range(0, full_mats.size()-1)], 0);
        end
    endtask

    // Result side: a random wait before each word, plus one long hold on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int gap;
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            vec_t exp_v;
            n_checked++;
            if (pending_vecs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word %h", $time, m_tdata);
            end
            else
            begin
                exp_v = pending_vecs.pop_front();
                if (m_tdata[31:0] !== exp_v.x)
                begin
                    errors++;
                    $display("%0t: out_x expected %h got %h", $time, exp_v.x, m_tdata[31:0]);
                end
                if (m_tdata[63:32] !== exp_v.y)
                begin
                    errors++;
                    $display("%0t: out_y expected %h got %h", $time, exp_v.y, m_tdata[63:32]);
                end
                if (m_tdata[95:64] !== exp_v.z)
                begin
                    errors++;
                    $display("%0t: out_z expected %h got %h", $time, exp_v.z, m_tdata[95:64]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = lbs_pkg::MODE_LOAD;
        hold_req   = 1'b0;
        errors     = 0;
        n_loads    = 0;
        n_blends   = 0;
        n_xforms   = 0;
        n_checked  = 0;
        idle_count = 0;
        for (int i = 0; i < TOTAL_MATS; i++)
            written[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        while (pending_vecs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d element loads, %0d blends and %0d transforms,", n_loads,
                 n_blends, n_xforms);
        $display("with %0d result words checked under random stalls and one long hold.",
                 n_checked);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
